[design/sqd_pkg.sv]
// Shared types, constants and ring index helper for the deque engine.
// No dependencies; sqd_ctrl, sqd_dpath and the top level refer to it by scoped names.
package sqd_pkg;

  // storage geometry
  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // port field widths
  localparam int REQ_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // request codes; the unused code behaves as nop
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_TOP = 3'd0,
    REQ_PUSH_BOT = 3'd1,
    REQ_POP      = 3'd2,
    REQ_SWAP     = 3'd3,
    REQ_ROT_L    = 3'd4,
    REQ_ROT_R    = 3'd5,
    REQ_NOP      = 3'd6
  } req_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_SWAP_SHORT = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_POP_DATA,
    CS_SWAP_DATA,
    CS_SWAP_FIX,
    CS_ROTL_DATA,
    CS_ROTR_DATA
  } ctl_state_t;

  // datapath step commands
  typedef enum logic [3:0] {
    DP_NONE,
    DP_PUSH_TOP,
    DP_PUSH_BOT,
    DP_POP_RD,
    DP_POP_FIN,
    DP_SWAP_RD,
    DP_SWAP_WB,
    DP_SWAP_WA,
    DP_ROTL_RD,
    DP_ROTL_FIN,
    DP_ROTR_RD,
    DP_ROTR_FIN
  } dp_op_t;

  // controller to datapath
  typedef struct packed {
    dp_op_t  op;
    logic    done;
    status_t status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic two_plus;
  } dp_flags_t;

  // ring index: (ptr + off) mod DEPTH, off no larger than DEPTH
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] ptr,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(ptr) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return PTR_W'(sum);
  endfunction

endpackage

[design/sqd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sqd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/sqd_ctrl.sv]
// Request sequencer for the deque engine: decodes a request and steps the
// datapath through its memory cycles. Depends on sqd_pkg.
module sqd_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [sqd_pkg::REQ_W-1:0]       req_type,
  input  sqd_pkg::dp_flags_t              flags,
  output logic                            busy,
  output sqd_pkg::dp_cmd_t                cmd
);

  sqd_pkg::ctl_state_t state;
  sqd_pkg::ctl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sqd_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd.op     = sqd_pkg::DP_NONE;
    cmd.done   = 1'b0;
    cmd.status = sqd_pkg::ST_OK;
    unique case (state)
      sqd_pkg::CS_IDLE: begin
        if (start) begin
          unique case (req_type)
            sqd_pkg::REQ_PUSH_TOP: begin
              cmd.done = 1'b1;
              if (flags.full) begin
                cmd.status = sqd_pkg::ST_FULL;
              end else begin
                cmd.op = sqd_pkg::DP_PUSH_TOP;
              end
            end
            sqd_pkg::REQ_PUSH_BOT: begin
              cmd.done = 1'b1;
              if (flags.full) begin
                cmd.status = sqd_pkg::ST_FULL;
              end else begin
                cmd.op = sqd_pkg::DP_PUSH_BOT;
              end
            end
            sqd_pkg::REQ_POP: begin
              if (flags.empty) begin
                cmd.done   = 1'b1;
                cmd.status = sqd_pkg::ST_POP_EMPTY;
              end else begin
                cmd.op     = sqd_pkg::DP_POP_RD;
                state_next = sqd_pkg::CS_POP_DATA;
              end
            end
            sqd_pkg::REQ_SWAP: begin
              if (!flags.two_plus) begin
                cmd.done   = 1'b1;
                cmd.status = sqd_pkg::ST_SWAP_SHORT;
              end else begin
                cmd.op     = sqd_pkg::DP_SWAP_RD;
                state_next = sqd_pkg::CS_SWAP_DATA;
              end
            end
            sqd_pkg::REQ_ROT_L: begin
              if (!flags.two_plus) begin
                cmd.done = 1'b1;
              end else begin
                cmd.op     = sqd_pkg::DP_ROTL_RD;
                state_next = sqd_pkg::CS_ROTL_DATA;
              end
            end
            sqd_pkg::REQ_ROT_R: begin
              if (!flags.two_plus) begin
                cmd.done = 1'b1;
              end else begin
                cmd.op     = sqd_pkg::DP_ROTR_RD;
                state_next = sqd_pkg::CS_ROTR_DATA;
              end
            end
            default: begin
              cmd.done = 1'b1;
            end
          endcase
        end
      end
      sqd_pkg::CS_POP_DATA: begin
        cmd.op     = sqd_pkg::DP_POP_FIN;
        cmd.done   = 1'b1;
        state_next = sqd_pkg::CS_IDLE;
      end
      sqd_pkg::CS_SWAP_DATA: begin
        cmd.op     = sqd_pkg::DP_SWAP_WB;
        state_next = sqd_pkg::CS_SWAP_FIX;
      end
      sqd_pkg::CS_SWAP_FIX: begin
        cmd.op     = sqd_pkg::DP_SWAP_WA;
        cmd.done   = 1'b1;
        state_next = sqd_pkg::CS_IDLE;
      end
      sqd_pkg::CS_ROTL_DATA: begin
        cmd.op     = sqd_pkg::DP_ROTL_FIN;
        cmd.done   = 1'b1;
        state_next = sqd_pkg::CS_IDLE;
      end
      sqd_pkg::CS_ROTR_DATA: begin
        cmd.op     = sqd_pkg::DP_ROTR_FIN;
        cmd.done   = 1'b1;
        state_next = sqd_pkg::CS_IDLE;
      end
      default: begin
        state_next = sqd_pkg::CS_IDLE;
      end
    endcase
  end

  assign busy = (state != sqd_pkg::CS_IDLE);

  // a swap always takes its second write right after the read data returns
  a_swap_fix: assert property (@(posedge clk) disable iff (rst)
    state == sqd_pkg::CS_SWAP_DATA |=> state == sqd_pkg::CS_SWAP_FIX)
    else $error("swap sequence broken");

  // no datapath step is issued for a request that reported an error
  a_err_no_op: assert property (@(posedge clk) disable iff (rst)
    cmd.done && cmd.status != sqd_pkg::ST_OK |-> cmd.op == sqd_pkg::DP_NONE)
    else $error("failed request changed state");

  // multi-cycle steps never run while idle
  a_busy_steps: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == sqd_pkg::DP_POP_FIN || cmd.op == sqd_pkg::DP_SWAP_WB ||
     cmd.op == sqd_pkg::DP_ROTL_FIN || cmd.op == sqd_pkg::DP_ROTR_FIN) |-> busy)
    else $error("data step outside a busy sequence");

endmodule

[design/sqd_dpath.sv]
// Datapath of the deque engine: ring pointers, fill count, cached top word,
// entry RAM and result registers. Depends on sqd_pkg and sqd_ram.
module sqd_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  sqd_pkg::dp_cmd_t              cmd,
  input  logic [sqd_pkg::VALUE_W-1:0]   push_value,
  output sqd_pkg::dp_flags_t            flags,
  output logic                          done,
  output logic [sqd_pkg::STATUS_W-1:0]  status,
  output logic [sqd_pkg::VALUE_W-1:0]   top_value,
  output logic [sqd_pkg::COUNT_W-1:0]   element_count
);

  localparam int DW = sqd_pkg::DATA_WIDTH;
  localparam int PW = sqd_pkg::PTR_W;
  localparam int CW = sqd_pkg::CNT_W;

  logic [PW-1:0]   top_ptr;
  logic [CW-1:0]   fill_cnt;
  logic [DW-1:0]   top_word;
  logic            done_q;
  sqd_pkg::status_t status_q;

  logic [PW-1:0]   ptr_inc;
  logic [PW-1:0]   ptr_dec;
  logic [PW-1:0]   ptr_off;
  logic [CW-1:0]   off_sel;
  logic [DW-1:0]   push_word;
  logic            ram_we;
  logic [PW-1:0]   ram_waddr;
  logic [DW-1:0]   ram_wdata;
  logic [PW-1:0]   ram_raddr;
  logic [DW-1:0]   ram_rdata;

  assign push_word = DW'(push_value);

  // ring neighbors of the top
  assign ptr_inc = sqd_pkg::ring_add(top_ptr, CW'(1));
  assign ptr_dec = (top_ptr == '0) ? PW'(sqd_pkg::DEPTH - 1) : top_ptr - PW'(1);
  assign off_sel = (cmd.op == sqd_pkg::DP_ROTR_RD) ? fill_cnt - CW'(1) : fill_cnt;
  assign ptr_off = sqd_pkg::ring_add(top_ptr, off_sel);

  // status toward the controller
  assign flags.empty    = (fill_cnt == '0);
  assign flags.full     = (fill_cnt == CW'(sqd_pkg::DEPTH));
  assign flags.two_plus = (fill_cnt >= CW'(2));

  // memory port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_off;
    ram_wdata = top_word;
    ram_raddr = ptr_inc;
    case (cmd.op)
      sqd_pkg::DP_PUSH_TOP: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_dec;
        ram_wdata = push_word;
      end
      sqd_pkg::DP_PUSH_BOT: begin
        ram_we    = 1'b1;
        ram_wdata = push_word;
      end
      sqd_pkg::DP_ROTL_RD: begin
        ram_we = 1'b1;
      end
      sqd_pkg::DP_ROTR_RD: begin
        ram_raddr = ptr_off;
      end
      sqd_pkg::DP_SWAP_WB: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_inc;
      end
      sqd_pkg::DP_SWAP_WA: begin
        ram_we    = 1'b1;
        ram_waddr = top_ptr;
      end
      sqd_pkg::DP_ROTR_FIN: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_dec;
        ram_wdata = ram_rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  sqd_ram #(
    .WIDTH (DW),
    .DEPTH (sqd_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // pointer and count updates
  always_ff @(posedge clk) begin
    if (rst) begin
      top_ptr  <= '0;
      fill_cnt <= '0;
    end else begin
      case (cmd.op)
        sqd_pkg::DP_PUSH_TOP: begin
          top_ptr  <= ptr_dec;
          fill_cnt <= fill_cnt + CW'(1);
        end
        sqd_pkg::DP_PUSH_BOT: begin
          fill_cnt <= fill_cnt + CW'(1);
        end
        sqd_pkg::DP_POP_FIN: begin
          top_ptr  <= ptr_inc;
          fill_cnt <= fill_cnt - CW'(1);
        end
        sqd_pkg::DP_ROTL_FIN: begin
          top_ptr <= ptr_inc;
        end
        sqd_pkg::DP_ROTR_FIN: begin
          top_ptr <= ptr_dec;
        end
        default: begin
          top_ptr <= top_ptr;
        end
      endcase
    end
  end

  // cached copy of the word at the top
  always_ff @(posedge clk) begin
    case (cmd.op)
      sqd_pkg::DP_PUSH_TOP: begin
        top_word <= push_word;
      end
      sqd_pkg::DP_PUSH_BOT: begin
        if (fill_cnt == '0) begin
          top_word <= push_word;
        end
      end
      sqd_pkg::DP_POP_FIN, sqd_pkg::DP_SWAP_WB, sqd_pkg::DP_ROTL_FIN,
      sqd_pkg::DP_ROTR_FIN: begin
        top_word <= ram_rdata;
      end
      default: begin
        top_word <= top_word;
      end
    endcase
  end

  // result strobe and status
  always_ff @(posedge clk) begin
    if (rst) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd.done;
    end
    status_q <= cmd.status;
  end

  assign done          = done_q;
  assign status        = status_q;
  assign top_value     = (fill_cnt == '0) ? '0 : sqd_pkg::VALUE_W'(top_word);
  assign element_count = sqd_pkg::COUNT_W'(fill_cnt);

  // fill count stays within the store
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    fill_cnt <= CW'(sqd_pkg::DEPTH))
    else $error("fill count beyond depth");

  // full is reported only with a full store
  a_full_rep: assert property (@(posedge clk) disable iff (rst)
    done_q && status_q == sqd_pkg::ST_FULL |-> fill_cnt == CW'(sqd_pkg::DEPTH))
    else $error("full reported on a store with room");

  // pop on empty is reported only with an empty store
  a_empty_rep: assert property (@(posedge clk) disable iff (rst)
    done_q && status_q == sqd_pkg::ST_POP_EMPTY |-> fill_cnt == '0)
    else $error("pop on empty reported on a filled store");

endmodule

[design/stack_queue_deque_engine_unit.sv]
// Top level of the bounded deque / stack / queue engine.
// Depends on sqd_pkg, sqd_ctrl and sqd_dpath (which holds sqd_ram).
//
//   channel   handshake            word
//   request   start, busy          req_type, push_value
//   result    done (one cycle)     status, top_value, element_count
//
// A request is taken at a clock edge with start high and busy low; its
// result shows on the result ports for one cycle with done high.
// Push, nop, rotate of fewer than two words and every failed request:
// result in the cycle after acceptance.
// Pop and rotate of two or more words read, then finish; swap reads, then
// writes twice; the RAM has one registered read port and one write port.
// rst is synchronous; afterwards the store is empty and top_value reads zero.
// The receiver cannot stall; busy stays high until the result cycle.
module stack_queue_deque_engine_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [sqd_pkg::REQ_W-1:0]     req_type,
  input  logic [sqd_pkg::VALUE_W-1:0]   push_value,
  output logic                          done,
  output logic [sqd_pkg::STATUS_W-1:0]  status,
  output logic [sqd_pkg::VALUE_W-1:0]   top_value,
  output logic [sqd_pkg::COUNT_W-1:0]   element_count
);

  sqd_pkg::dp_cmd_t   cmd;
  sqd_pkg::dp_flags_t flags;

  // request sequencer
  sqd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .flags    (flags),
    .busy     (busy),
    .cmd      (cmd)
  );

  // storage and result registers
  sqd_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .push_value    (push_value),
    .flags         (flags),
    .done          (done),
    .status        (status),
    .top_value     (top_value),
    .element_count (element_count)
  );

endmodule

[sim/tb_stack_queue_deque_engine_unit.sv]
// Testbench for the deque / stack / queue engine: directed corner requests, then
// phased random traffic, each result checked against an in-bench deque predictor.
// Depends on sqd_pkg and stack_queue_deque_engine_unit.

module tb_stack_queue_deque_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // one expected or observed result word
  typedef struct packed {
    sqd_pkg::status_t             status;
    logic [sqd_pkg::VALUE_W-1:0] top_word;
    logic [sqd_pkg::COUNT_W-1:0] word_count;
  } deque_result_t;

  // deque predictor plus in-order result checker
  class deque_scoreboard;
    logic [sqd_pkg::DATA_WIDTH-1:0] ring_mem [sqd_pkg::DEPTH];
    int unsigned top_idx = 0;
    int unsigned fill = 0;
    deque_result_t expected_q[$];
    int unsigned mismatches = 0;

    function int unsigned slot(int unsigned offset);
      return (top_idx + offset) % sqd_pkg::DEPTH;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // apply one accepted request to the predicted deque and queue its result
    function void note_request(logic [sqd_pkg::REQ_W-1:0] code,
                               logic [sqd_pkg::VALUE_W-1:0] word);
      logic [sqd_pkg::DATA_WIDTH-1:0] held;
      int unsigned a;
      int unsigned b;
      deque_result_t res;
      res.status = sqd_pkg::ST_OK;
      case (code)
        sqd_pkg::REQ_PUSH_TOP: begin
          if (fill >= sqd_pkg::DEPTH) begin
            res.status = sqd_pkg::ST_FULL;
          end else begin
            top_idx = slot(sqd_pkg::DEPTH - 1);
            ring_mem[top_idx] = sqd_pkg::DATA_WIDTH'(word);
            fill++;
          end
        end
        sqd_pkg::REQ_PUSH_BOT: begin
          if (fill >= sqd_pkg::DEPTH) begin
            res.status = sqd_pkg::ST_FULL;
          end else begin
            ring_mem[slot(fill)] = sqd_pkg::DATA_WIDTH'(word);
            fill++;
          end
        end
        sqd_pkg::REQ_POP: begin
          if (fill == 0) begin
            res.status = sqd_pkg::ST_POP_EMPTY;
          end else begin
            top_idx = slot(1);
            fill--;
          end
        end
        sqd_pkg::REQ_SWAP: begin
          if (fill < 2) begin
            res.status = sqd_pkg::ST_SWAP_SHORT;
          end else begin
            a = slot(0);
            b = slot(1);
            held = ring_mem[a];
            ring_mem[a] = ring_mem[b];
            ring_mem[b] = held;
          end
        end
        // top word moves below the bottom
        sqd_pkg::REQ_ROT_L: begin
          if (fill >= 2) begin
            ring_mem[slot(fill)] = ring_mem[slot(0)];
            top_idx = slot(1);
          end
        end
        // bottom word moves above the top
        sqd_pkg::REQ_ROT_R: begin
          if (fill >= 2) begin
            held = ring_mem[slot(fill - 1)];
            top_idx = slot(sqd_pkg::DEPTH - 1);
            ring_mem[top_idx] = held;
          end
        end
        default: begin
        end
      endcase
      res.top_word = (fill == 0) ? '0 : sqd_pkg::VALUE_W'(ring_mem[top_idx]);
      res.word_count = sqd_pkg::COUNT_W'(fill);
      expected_q.push_back(res);
    endfunction

    // compare one result word with the oldest expectation
    function void check_result(deque_result_t got);
      deque_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: result with nothing expected: status %0d top %h count %0d",
                   got.status, got.top_word, got.word_count);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.top_word !== want.top_word ||
          got.word_count !== want.word_count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t: expected status %0d top %h count %0d,",
                   $realtime, want.status, want.top_word, want.word_count);
          $display("  got status %0d top %h count %0d",
                   got.status, got.top_word, got.word_count);
        end
      end
    endfunction
  endclass

  localparam int CLK_PERIOD = 8;
  localparam int RESET_CYCLES = 7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 467;
  localparam int FLUSH_CYCLES = 8;
  // code 7 is not a request; the block treats it as nop
  localparam logic [sqd_pkg::REQ_W-1:0] REQ_UNDEF = 3'd7;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [sqd_pkg::REQ_W-1:0] req_type = '0;
  logic [sqd_pkg::VALUE_W-1:0] push_value = '0;
  logic busy;
  logic done;
  logic [sqd_pkg::STATUS_W-1:0] status;
  logic [sqd_pkg::VALUE_W-1:0] top_value;
  logic [sqd_pkg::COUNT_W-1:0] element_count;

  deque_scoreboard deque_sb = new;
  int unsigned gap_pct = 0;
  int unsigned stall_cycles = 0;

  stack_queue_deque_engine_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .push_value    (push_value),
    .done          (done),
    .status        (status),
    .top_value     (top_value),
    .element_count (element_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      deque_sb.check_result(deque_result_t'{sqd_pkg::status_t'(status), top_value,
                                            element_count});
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // present one request word, with a random gap first, and wait for acceptance
  task automatic send_request(input logic [sqd_pkg::REQ_W-1:0] code,
                              input logic [sqd_pkg::VALUE_W-1:0] word);
    int unsigned gaps;
    gaps = 0;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      gaps++;
    end
    if (gaps != 0) begin
      start <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= code;
    push_value <= word;
    do @(posedge clk); while (busy);
    deque_sb.note_request(code, word);
  endtask

  // hold off the sender until every expected result is back
  task automatic drain_results();
    start <= 1'b0;
    while (deque_sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [sqd_pkg::REQ_W-1:0] pick_code(traffic_mode_t mode);
    int unsigned r;
    r = $urandom_range(99);
    case (mode)
      MODE_FILL: begin
        if (r < 90) begin
          return ($urandom_range(1) != 0) ? sqd_pkg::REQ_PUSH_BOT : sqd_pkg::REQ_PUSH_TOP;
        end
        return sqd_pkg::REQ_W'($urandom_range(2, 7));
      end
      MODE_DRAIN: begin
        if (r < 85) begin
          return sqd_pkg::REQ_POP;
        end
        return sqd_pkg::REQ_W'($urandom_range(0, 7));
      end
      default: return sqd_pkg::REQ_W'($urandom_range(0, 7));
    endcase
  endfunction

  // mostly random words, some all-zero, all-one and one-hot
  function automatic logic [sqd_pkg::VALUE_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return sqd_pkg::VALUE_W'(1) << $urandom_range(sqd_pkg::VALUE_W - 1);
      default: return sqd_pkg::VALUE_W'($urandom);
    endcase
  endfunction

  initial begin
    traffic_mode_t mode;
    int unsigned seg;
    int unsigned seg_len;
    int unsigned sent;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty-store pop and swap failures, rotates, nop and the unused code
    send_request(sqd_pkg::REQ_POP, '1);
    send_request(sqd_pkg::REQ_SWAP, '0);
    send_request(sqd_pkg::REQ_ROT_L, '0);
    send_request(sqd_pkg::REQ_ROT_R, '0);
    send_request(sqd_pkg::REQ_NOP, 32'hdead_beef);
    send_request(REQ_UNDEF, 32'h5555_aaaa);
    // single element: swap short, rotates leave it alone
    send_request(sqd_pkg::REQ_PUSH_TOP, '0);
    send_request(sqd_pkg::REQ_SWAP, '0);
    send_request(sqd_pkg::REQ_ROT_L, '0);
    send_request(sqd_pkg::REQ_ROT_R, '0);
    send_request(sqd_pkg::REQ_POP, '0);
    // a few words from both ends, then swap and rotate both ways
    send_request(sqd_pkg::REQ_PUSH_BOT, '1);
    send_request(sqd_pkg::REQ_PUSH_TOP, 32'h1234_5678);
    send_request(sqd_pkg::REQ_PUSH_BOT, 32'h8000_0000);
    send_request(sqd_pkg::REQ_PUSH_TOP, 32'h0000_0001);
    send_request(sqd_pkg::REQ_SWAP, '0);
    send_request(sqd_pkg::REQ_ROT_L, '0);
    send_request(sqd_pkg::REQ_ROT_R, '0);
    send_request(sqd_pkg::REQ_ROT_R, '0);
    send_request(sqd_pkg::REQ_POP, '0);
    send_request(sqd_pkg::REQ_POP, '0);
    send_request(sqd_pkg::REQ_POP, '0);
    send_request(sqd_pkg::REQ_POP, '0);
    send_request(sqd_pkg::REQ_POP, '0);
    drain_results();

    // random phases: sender gap odds of 35 %, 47 %, then none; each opens with a push-heavy fill segment
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 35 : (ph == 1) ? 47 : 0;
      sent = 0;
      seg = 0;
      while (sent < ITEMS_PER_PHASE) begin
        mode = (seg == 0) ? MODE_FILL : traffic_mode_t'($urandom_range(2));
        seg_len = (seg == 0) ? 100 : $urandom_range(40, 120);
        for (int k = 0; k < seg_len && sent < ITEMS_PER_PHASE; k++) begin
          send_request(pick_code(mode), pick_word());
          sent++;
        end
        seg++;
      end
      drain_results();
    end

    repeat (FLUSH_CYCLES) @(posedge clk);
    if (deque_sb.mismatches == 0 && deque_sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
design/sqd_pkg.sv
design/sqd_ram.sv
design/sqd_ctrl.sv
design/sqd_dpath.sv
design/stack_queue_deque_engine_unit.sv
sim/tb_stack_queue_deque_engine_unit.sv
